// ----- hdl/rle8_pkg.sv -----
// Package for the RLE8 bitmap decoder: transfer payload types, parse phases,
// result kinds, configuration indexes and reset values. No dependencies.
`default_nettype none

package rle8_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 13'd4096;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 13'd4096;

    localparam int OFIFO_DEPTH = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TOP_DOWN     = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_COUNT = 3'd1,
        PH_VALUE = 3'd2,
        PH_DX    = 3'd3,
        PH_DY    = 3'd4,
        PH_ABS   = 3'd5,
        PH_PAD   = 3'd6,
        PH_DONE  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_RUN    = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] run_x;
        logic [11:0] run_y;
        logic [7:0]  run_length;
        logic [7:0]  pixel_index;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic                  top_down;
        logic [CFG_DATA_W-1:0] frame_width;
        logic [CFG_DATA_W-1:0] frame_height;
    } t_cfg;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_push;

    function automatic t_out_item mk_item(t_kind kind, logic [11:0] x, logic [11:0] y,
                                          logic [7:0] len, logic [7:0] pix);
        t_out_item r;
        r.kind        = kind;
        r.run_x       = x;
        r.run_y       = y;
        r.run_length  = len;
        r.pixel_index = pix;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rle8_parse.sv -----
// Byte parser of the RLE8 decoder: parse phase, position and command state,
// and the up to two results each byte causes. Depends on rle8_pkg.
`default_nettype none

module rle8_parse
    import rle8_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_push         o_push
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CW = (WW > CFG_DATA_W) ? WW + 1 : CFG_DATA_W + 1;
    localparam int CHW = (HW > CFG_DATA_W) ? HW + 1 : CFG_DATA_W + 1;
    localparam int LW = (WW > 8) ? WW : 8;
    localparam int XW = LW + 1;
    localparam int SW = ((HW > 9) ? HW : 9) + 2;

    t_phase          r_phase, n_phase;
    logic [WW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [7:0]      r_held_count, n_held_count;
    logic [7:0]      r_abs_left, n_abs_left;
    logic            r_pad, n_pad;
    logic [7:0]      r_held_dx, n_held_dx;

    logic [WW-1:0]        eff_w;
    logic [HW-1:0]        eff_h;
    logic [RW-1:0]        first_row;
    logic [WW-1:0]        avail;
    logic [7:0]           run_len;
    logic signed [SW-1:0] row_s, h_s, ny_eol, ny_delta;
    logic [XW-1:0]        nx;
    logic                 eol_off, delta_off;
    logic [7:0]           b;
    logic                 run_v, end_v;
    t_kind                end_kind;
    t_out_item            run_item, end_item;

    always_comb begin
        b = i_item.data_byte;

        if (i_cfg.frame_width == '0) begin
            eff_w = WW'(1);
        end else if (CW'(i_cfg.frame_width) > CW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(i_cfg.frame_width);
        end

        if (i_cfg.frame_height == '0) begin
            eff_h = HW'(1);
        end else if (CHW'(i_cfg.frame_height) > CHW'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(i_cfg.frame_height);
        end

        first_row = i_cfg.top_down ? RW'(eff_h - HW'(1)) : '0;

        if ((HW'(r_row) < eff_h) && (r_col < eff_w)) begin
            avail = eff_w - r_col;
        end else begin
            avail = '0;
        end

        if (LW'(r_held_count) < LW'(avail)) begin
            run_len = r_held_count;
        end else begin
            run_len = 8'(LW'(avail));
        end

        row_s    = signed'(SW'(r_row));
        h_s      = signed'(SW'(eff_h));
        ny_eol   = i_cfg.top_down ? row_s - SW'(1) : row_s + SW'(1);
        ny_delta = i_cfg.top_down ? row_s - signed'(SW'(b)) : row_s + signed'(SW'(b));
        nx       = XW'(r_col) + XW'(r_held_dx);
        eol_off  = (ny_eol < 0) || (ny_eol >= h_s);
        delta_off = (nx >= XW'(eff_w)) || (ny_delta < 0) || (ny_delta >= h_s);
    end

    always_comb begin
        n_phase      = r_phase;
        n_col        = r_col;
        n_row        = r_row;
        n_held_count = r_held_count;
        n_abs_left   = r_abs_left;
        n_pad        = r_pad;
        n_held_dx    = r_held_dx;
        run_v        = 1'b0;
        end_v        = 1'b0;
        end_kind     = KIND_FINISH;
        run_item     = mk_item(KIND_RUN, 12'(r_col), 12'(r_row), run_len, b);

        case (r_phase)
            PH_START: begin
                n_row        = first_row;
                n_col        = '0;
                n_held_count = b;
                n_phase      = PH_VALUE;
            end
            PH_COUNT: begin
                n_held_count = b;
                n_phase      = PH_VALUE;
            end
            PH_VALUE: begin
                if (r_held_count != 8'd0) begin
                    run_v = (run_len != 8'd0);
                    n_col = r_col + WW'(run_len);
                    if (run_len != r_held_count) begin
                        end_v    = 1'b1;
                        end_kind = KIND_ERROR;
                        n_phase  = PH_DONE;
                    end else begin
                        n_phase = PH_COUNT;
                    end
                end else if (b == 8'd0) begin
                    n_col = '0;
                    if (eol_off) begin
                        end_v   = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_row   = RW'(ny_eol);
                        n_phase = PH_COUNT;
                    end
                end else if (b == 8'd1) begin
                    end_v   = 1'b1;
                    n_phase = PH_DONE;
                end else if (b == 8'd2) begin
                    n_phase = PH_DX;
                end else begin
                    n_abs_left = b;
                    n_pad      = b[0];
                    n_phase    = PH_ABS;
                end
            end
            PH_DX: begin
                n_held_dx = b;
                n_phase   = PH_DY;
            end
            PH_DY: begin
                if (delta_off) begin
                    end_v    = 1'b1;
                    end_kind = KIND_ERROR;
                    n_phase  = PH_DONE;
                end else begin
                    n_col   = WW'(nx);
                    n_row   = RW'(ny_delta);
                    n_phase = PH_COUNT;
                end
            end
            PH_ABS: begin
                if (avail == '0) begin
                    end_v    = 1'b1;
                    end_kind = KIND_ERROR;
                    n_phase  = PH_DONE;
                end else begin
                    run_v      = 1'b1;
                    run_item   = mk_item(KIND_RUN, 12'(r_col), 12'(r_row), 8'd1, b);
                    n_col      = r_col + WW'(1);
                    n_abs_left = r_abs_left - 8'd1;
                    if (r_abs_left == 8'd1) begin
                        n_phase = r_pad ? PH_PAD : PH_COUNT;
                    end
                end
            end
            PH_PAD: begin
                n_pad   = 1'b0;
                n_phase = PH_COUNT;
            end
            default: begin
            end
        endcase

        if (i_item.last_byte) begin
            if (n_phase == PH_COUNT) begin
                end_v    = 1'b1;
                end_kind = KIND_FINISH;
            end else if (n_phase != PH_DONE) begin
                end_v    = 1'b1;
                end_kind = KIND_ERROR;
            end
            n_phase      = PH_START;
            n_col        = '0;
            n_row        = first_row;
            n_held_count = '0;
            n_abs_left   = '0;
            n_pad        = 1'b0;
            n_held_dx    = '0;
        end

        end_item      = mk_item(end_kind, '0, '0, '0, '0);
        end_item.last = 1'b1;
        run_item.last = !end_v;
    end

    always_comb begin
        o_push.count  = i_accept ? (2'(run_v) + 2'(end_v)) : 2'd0;
        o_push.first  = run_v ? run_item : end_item;
        o_push.second = end_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_col        <= '0;
            r_row        <= '0;
            r_held_count <= '0;
            r_abs_left   <= '0;
            r_pad        <= 1'b0;
            r_held_dx    <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_col        <= n_col;
            r_row        <= n_row;
            r_held_count <= n_held_count;
            r_abs_left   <= n_abs_left;
            r_pad        <= n_pad;
            r_held_dx    <= n_held_dx;
        end
    end

    // An ended frame ignores every byte except its last one.
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_DONE && !i_item.last_byte) |-> (o_push.count == 2'd0))
        else $error("ended frame produced a result");

    // The last byte of a frame always rearms the parser.
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.last_byte) |=> (r_phase == PH_START && r_col == '0))
        else $error("parser not rearmed after last byte");

    // A second result of one byte is always a frame end.
    a_second_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (o_push.first.kind == KIND_RUN
            && o_push.second.kind != KIND_RUN))
        else $error("bad result pair");

endmodule

`default_nettype wire

// ----- hdl/rle8_ofifo.sv -----
// Result queue of the RLE8 decoder: takes up to two results per cycle and
// hands out one per output transfer. Depends on rle8_pkg.
`default_nettype none

module rle8_ofifo
    import rle8_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_space,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_out_item  o_item
);

    localparam int PW = $clog2(OFIFO_DEPTH);
    localparam int CNW = $clog2(OFIFO_DEPTH + 1);

    t_out_item       r_mem [OFIFO_DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CNW-1:0]  r_count, n_count;
    logic            pop;

    always_comb begin
        pop     = o_valid && i_ready;
        n_wr    = r_wr + PW'(i_push.count);
        n_rd    = r_rd + PW'(pop);
        n_count = r_count + CNW'(i_push.count) - CNW'(pop);
        o_valid = (r_count != '0);
        o_space = (r_count <= CNW'(OFIFO_DEPTH - 2));
        o_item  = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_space)
        else $error("result queue written without room");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.count == 2'd0) |=> (r_count == $past(r_count) - CNW'(1)))
        else $error("result queue count lost a transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNW'(OFIFO_DEPTH)))
        else $error("result queue count beyond depth");

endmodule

`default_nettype wire

// ----- hdl/rle8_bitmap_decoder.sv -----
// Top level of the RLE8 bitmap decoder: configuration registers, byte parser
// and result queue. Depends on rle8_pkg, rle8_parse and rle8_ofifo.
//
//   Channel   Direction  Handshake                Payload
//   input     in         i_in_valid / o_in_ready  i_in_item (t_in_item)
//   output    out        o_out_valid / i_out_ready o_out_item (t_out_item)
//   config    in         i_cfg_we                 i_cfg_addr, i_cfg_data
//
// Each byte is parsed in the cycle of its transfer and its results land in a
// four-entry queue, so a result appears in the cycle after the byte arrives.
// A byte is taken whenever the queue has room for two results; one byte per
// cycle is sustained while the output side keeps pace with the results.
// Synchronous active-low reset clears the parser, the queue and the registers.
// A stalled output only stops input once the queue cannot take two results.
`default_nettype none

module rle8_bitmap_decoder
    import rle8_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_push push;
    logic  accept;
    logic  space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top_down     <= 1'b0;
            r_cfg.frame_width  <= RST_FRAME_WIDTH;
            r_cfg.frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TOP_DOWN:     r_cfg.top_down     <= i_cfg_data[0];
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    rle8_parse #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_push   (push)
    );

    rle8_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ----- tb/rle8_tb_pkg.sv -----
// Scoreboard for the RLE8 bitmap decoder bench: a byte-level decoder of the
// command stream that predicts pixel runs and frame status, plus the checker.
// Depends on rle8_pkg.
package rle8_tb_pkg;
    import rle8_pkg::*;

    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    class rle8_scoreboard;
        logic        top_down;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        t_phase      phase;
        int          col;
        int          row;
        int          held_count;
        int          abs_left;
        bit          pad_pending;
        int          held_dx;
        t_out_item   staged_cmd;
        bit          staged;
        t_out_item   expected_cmds[$];
        int          errors;
        int          live_bytes;

        function new();
            top_down     = 1'b0;
            frame_width  = RST_FRAME_WIDTH;
            frame_height = RST_FRAME_HEIGHT;
            errors       = 0;
            live_bytes   = 0;
            staged       = 1'b0;
            arm();
        endfunction

        function int used_width();
            if (frame_width == 0) return 1;
            if (frame_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
            return frame_width;
        endfunction

        function int used_height();
            if (frame_height == 0) return 1;
            if (frame_height > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
            return frame_height;
        endfunction

        function int first_row();
            return top_down ? used_height() - 1 : 0;
        endfunction

        function void arm();
            phase       = PH_START;
            col         = 0;
            row         = first_row();
            held_count  = 0;
            abs_left    = 0;
            pad_pending = 1'b0;
            held_dx     = 0;
        endfunction

        function int room();
            if (row < 0 || row >= used_height() || col >= used_width()) return 0;
            return used_width() - col;
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void set_register(t_cfg_index idx, logic [12:0] value);
            case (idx)
                CFG_TOP_DOWN:     top_down = value[0];
                CFG_FRAME_WIDTH:  frame_width = value;
                CFG_FRAME_HEIGHT: frame_height = value;
                default: ;
            endcase
        endfunction

        function void emit(t_kind kind, int x, int y, int len, int pix);
            if (staged) expected_cmds.push_back(staged_cmd);
            staged_cmd.kind        = kind;
            staged_cmd.run_x       = 12'(x);
            staged_cmd.run_y       = 12'(y);
            staged_cmd.run_length  = 8'(len);
            staged_cmd.pixel_index = 8'(pix);
            staged_cmd.last        = 1'b0;
            staged = 1'b1;
        endfunction

        function void note_byte(t_in_item item);
            int bv;
            int step;
            int avail;
            int len;
            int nx;
            int ny;
            bv   = item.data_byte;
            step = top_down ? -1 : 1;
            live_bytes++;
            case (phase)
                PH_START, PH_COUNT: begin
                    if (phase == PH_START) begin
                        row = first_row();
                        col = 0;
                    end
                    held_count = bv;
                    phase = PH_VALUE;
                end
                PH_VALUE: begin
                    if (held_count != 0) begin
                        avail = room();
                        len = (held_count < avail) ? held_count : avail;
                        if (len != 0) emit(KIND_RUN, col, row, len, bv);
                        col += len;
                        if (len < held_count) begin
                            emit(KIND_ERROR, 0, 0, 0, 0);
                            phase = PH_DONE;
                        end else begin
                            phase = PH_COUNT;
                        end
                    end else if (bv == ESC_EOL) begin
                        ny  = row + step;
                        col = 0;
                        if (ny < 0 || ny >= used_height()) begin
                            emit(KIND_FINISH, 0, 0, 0, 0);
                            phase = PH_DONE;
                        end else begin
                            row = ny;
                            phase = PH_COUNT;
                        end
                    end else if (bv == ESC_EOB) begin
                        emit(KIND_FINISH, 0, 0, 0, 0);
                        phase = PH_DONE;
                    end else if (bv == ESC_DELTA) begin
                        phase = PH_DX;
                    end else begin
                        abs_left    = bv;
                        pad_pending = bv[0];
                        phase = PH_ABS;
                    end
                end
                PH_DX: begin
                    held_dx = bv;
                    phase = PH_DY;
                end
                PH_DY: begin
                    nx = col + held_dx;
                    ny = row + step * bv;
                    if (nx >= used_width() || ny < 0 || ny >= used_height()) begin
                        emit(KIND_ERROR, 0, 0, 0, 0);
                        phase = PH_DONE;
                    end else begin
                        col = nx;
                        row = ny;
                        phase = PH_COUNT;
                    end
                end
                PH_ABS: begin
                    if (room() == 0) begin
                        emit(KIND_ERROR, 0, 0, 0, 0);
                        phase = PH_DONE;
                    end else begin
                        emit(KIND_RUN, col, row, 1, bv);
                        col++;
                        abs_left--;
                        if (abs_left == 0) phase = pad_pending ? PH_PAD : PH_COUNT;
                    end
                end
                PH_PAD: begin
                    pad_pending = 1'b0;
                    phase = PH_COUNT;
                end
                default: ;
            endcase
            if (item.last_byte) begin
                if (phase == PH_COUNT) emit(KIND_FINISH, 0, 0, 0, 0);
                else if (phase != PH_DONE) emit(KIND_ERROR, 0, 0, 0, 0);
                arm();
            end
            if (staged) begin
                staged_cmd.last = 1'b1;
                expected_cmds.push_back(staged_cmd);
                staged = 1'b0;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_cmds.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind=%0d x=%0d y=%0d len=%0d pix=%0d last=%0d",
                         $time, got.kind, got.run_x, got.run_y, got.run_length,
                         got.pixel_index, got.last);
                return;
            end
            want = expected_cmds.pop_front();
            if (got.kind !== want.kind || got.run_x !== want.run_x
                    || got.run_y !== want.run_y || got.run_length !== want.run_length
                    || got.pixel_index !== want.pixel_index || got.last !== want.last) begin
                errors++;
                $display("%0t: mismatch expected kind=%0d x=%0d y=%0d len=%0d pix=%0d last=%0d",
                         $time, want.kind, want.run_x, want.run_y, want.run_length,
                         want.pixel_index, want.last);
                $display("%0t:          actual   kind=%0d x=%0d y=%0d len=%0d pix=%0d last=%0d",
                         $time, got.kind, got.run_x, got.run_y, got.run_length,
                         got.pixel_index, got.last);
            end
        endfunction
    endclass

endpackage

// ----- tb/testbench.sv -----
// Top-level bench for rle8_bitmap_decoder: directed frames, then random RLE8
// frames under several register settings with bursty input and output stalls.
// Depends on rle8_pkg, rle8_tb_pkg and the decoder RTL.
module testbench;
    import rle8_pkg::*;
    import rle8_tb_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rle8_scoreboard sb;
    logic [7:0]     frame_bytes[$];
    int             burst_left;
    int             max_gap;

    rle8_bitmap_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int stall_left;
        int stall_pct;
        int cyc;
        i_out_ready = 1'b0;
        stall_left  = 0;
        stall_pct   = 0;
        cyc         = 0;
        forever begin
            @(negedge i_clk);
            if (cyc % 300 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            cyc++;
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    task automatic send_byte(input logic [7:0] value, input logic closes);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_item.data_byte = value;
        i_in_item.last_byte = closes;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_byte(i_in_item);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input bit closes);
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], closes && (i == frame_bytes.size() - 1));
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input int value);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_register(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic configure(input bit td, input int width, input int height);
        write_reg(CFG_TOP_DOWN, ($urandom_range(0, 4095) << 1) | td);
        write_reg(CFG_FRAME_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 9))
            7: return 4096;
            8: return ($urandom_range(0, 1) != 0) ? 8191 : 0;
            9: return $urandom_range(1, 8191);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    function automatic void build_frame();
        int cmds;
        int pick;
        int lim;
        int n;
        int cut;
        lim = sb.used_width();
        if (lim > 255) lim = 255;
        frame_bytes = {};
        cmds = $urandom_range(1, 12);
        repeat (cmds) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255)
                                                  : $urandom_range(1, (lim + 1) / 2);
                frame_bytes.push_back(8'(n));
                frame_bytes.push_back(8'($urandom));
            end else if (pick < 55) begin
                frame_bytes.push_back(8'd0);
                frame_bytes.push_back(ESC_EOL);
            end else if (pick < 68) begin
                frame_bytes.push_back(8'd0);
                frame_bytes.push_back(ESC_DELTA);
                frame_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                                   : 8'($urandom_range(0, 3)));
                frame_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                                   : 8'($urandom_range(0, 2)));
            end else if (pick < 88) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 255)
                                                  : $urandom_range(3, 8);
                frame_bytes.push_back(8'd0);
                frame_bytes.push_back(8'(n));
                repeat (n) frame_bytes.push_back(8'($urandom));
                if (n % 2 != 0) frame_bytes.push_back(8'($urandom));
            end else if (pick < 94) begin
                frame_bytes.push_back(8'd0);
                frame_bytes.push_back(ESC_EOB);
                repeat ($urandom_range(1, 2)) frame_bytes.push_back(8'($urandom));
            end else begin
                frame_bytes.push_back(8'($urandom));
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(0, frame_bytes.size() - 1);
            repeat (cut) void'(frame_bytes.pop_back());
        end
    endfunction

    initial begin
        int p;
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_data  = '0;
        burst_left  = 0;
        max_gap     = 3;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        frame_bytes = {8'd255, 8'd255, 8'd0, 8'd3, 8'd1, 8'd2, 8'd255, 8'd0,
                       8'd0, ESC_EOL, 8'd0, ESC_DELTA, 8'd5, 8'd1, 8'd0, ESC_EOB, 8'd7};
        send_frame(1'b1);
        settle();
        configure(1'b1, 4, 2);
        frame_bytes = {8'd3, 8'd9, 8'd5, 8'd4, 8'd200, 8'd0};
        send_frame(1'b1);
        frame_bytes = {8'd5};
        send_frame(1'b1);
        settle();
        configure(1'b0, 0, 8191);
        frame_bytes = {8'd0, ESC_DELTA, 8'd0, 8'd6};
        send_frame(1'b0);
        settle();
        // Shrink the frame under the current row so the next run lands off the frame.
        write_reg(CFG_FRAME_HEIGHT, 4);
        frame_bytes = {8'd1, 8'd5};
        send_frame(1'b1);
        frame_bytes = {8'd0, 8'd3, 8'd1, 8'd2};
        send_frame(1'b1);
        frame_bytes = {8'd0, ESC_DELTA, 8'd1, 8'd0};
        send_frame(1'b1);

        p = 0;
        while (sb.live_bytes < 650) begin
            settle();
            case (p)
                0: configure(1'b0, 1, 1);
                1: configure(1'b1, 4096, 4096);
                2: configure(1'b1, 0, 8191);
                3: configure(1'b0, 8191, 0);
                default: configure($urandom_range(0, 1), pick_dim(), pick_dim());
            endcase
            max_gap = (p % 3 == 2) ? 0 : $urandom_range(1, 8);
            repeat ($urandom_range(3, 8)) begin
                build_frame();
                send_frame(1'b1);
            end
            p++;
        end
        settle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
